/* rtl/l_route_edge_utilization_defines.svh */
// Assertion helpers for the edge utilisation router; clk and rst_n must be in scope.
`ifndef L_ROUTE_EDGE_UTILIZATION_DEFINES_SVH
`define L_ROUTE_EDGE_UTILIZATION_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define LRUE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define LRUE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lrue_pkg.sv */
`default_nettype none
package lrue_pkg;

  // Field widths
  localparam int COORD_W     = 5;
  localparam int DIM_W       = 6;
  localparam int EDGE_W      = 11;
  localparam int UTIL_W      = 16;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  // Parameter defaults
  localparam int MAX_GRID_DEF   = 32;
  localparam int EDGE_SLOTS_DEF = 2048;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ROUTE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SETCAP  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_CAP     = 2'd2;

  // Configuration reset values
  localparam logic [DIM_W-1:0]  GRID_WIDTH_RST  = 6'd32;
  localparam logic [DIM_W-1:0]  GRID_HEIGHT_RST = 6'd32;
  localparam logic [UTIL_W-1:0] DEF_CAP_RST     = 16'd1;

  // Operation carried from the front to the back
  typedef enum logic [1:0] {
    OP_ROUTE   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SETCAP  = 2'd2
  } op_t;

  // One queued word: a classified, checked item ready to be walked
  typedef struct packed {
    op_t                op;
    logic [EDGE_W-1:0]  edge_idx;  // first horizontal edge, or target edge
    logic [COORD_W-1:0] h_steps;
    logic               h_up;
    logic [EDGE_W-1:0]  v_start;
    logic [COORD_W-1:0] v_steps;
    logic               v_up;
    logic [UTIL_W-1:0]  cap;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/lrue_fifo.sv */
`default_nettype none
module lrue_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lrue_pkg::cmd_t wr_cmd,
  input  wire logic          pop,
  output lrue_pkg::cmd_t     rd_cmd,
  output logic               full,
  output logic               empty
);
  import lrue_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full   = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_r == '0);
  assign rd_cmd = slot_r[rd_ptr_r];

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold the queued words
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

/* rtl/lrue_front.sv */
`default_nettype none
module lrue_front #(
  parameter int EDGE_SLOTS = lrue_pkg::EDGE_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic [lrue_pkg::KIND_W-1:0]   kind,
  input  wire logic [lrue_pkg::COORD_W-1:0]  src_x,
  input  wire logic [lrue_pkg::COORD_W-1:0]  src_y,
  input  wire logic [lrue_pkg::COORD_W-1:0]  dst_x,
  input  wire logic [lrue_pkg::COORD_W-1:0]  dst_y,
  input  wire logic [lrue_pkg::EDGE_W-1:0]   target_edge,
  input  wire logic [lrue_pkg::UTIL_W-1:0]   capacity_value,
  input  wire logic [lrue_pkg::DIM_W-1:0]    grid_w,
  input  wire logic [lrue_pkg::DIM_W-1:0]    grid_h,
  input  wire logic [lrue_pkg::EDGE_W-1:0]   hcount,
  input  wire logic [lrue_pkg::EDGE_W-1:0]   total,
  input  wire logic                          fifo_full,
  output logic                               push,
  output lrue_pkg::cmd_t                     cmd,
  output logic                               idle
);
  import lrue_pkg::*;

  localparam int TOP_W = EDGE_W + 1;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MULH = 5'b00010,
    F_MULT = 5'b00100,
    F_MULV = 5'b01000,
    F_PUSH = 5'b10000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [KIND_W-1:0]  kind_r;
  logic [COORD_W-1:0] sx_r, sy_r, dx_r, dy_r;
  logic [EDGE_W-1:0]  tgt_r;
  logic [UTIL_W-1:0]  capv_r;
  logic [EDGE_W-1:0]  hrow_r, vtop_r, vrow_r;

  logic               x_up, y_up, y_move;
  logic [COORD_W-1:0] xmax, ymax, h_steps, v_steps, h_first, v_first;
  logic [COORD_W-1:0] mul_a;
  logic [DIM_W-1:0]   mul_b;
  logic [EDGE_W-1:0]  prod;
  logic               off_grid, same_pin, tgt_bad, top_bad, drop;
  logic [TOP_W-1:0]   top_w;
  op_t                op;

  // Classify the held item
  always_comb begin
    x_up    = (dx_r > sx_r);
    y_up    = (dy_r > sy_r);
    y_move  = (sy_r != dy_r);
    xmax    = x_up ? dx_r : sx_r;
    ymax    = y_up ? dy_r : sy_r;
    h_steps = x_up ? dx_r - sx_r : sx_r - dx_r;
    v_steps = y_up ? dy_r - sy_r : sy_r - dy_r;
    h_first = x_up ? sx_r : sx_r - 1'b1;
    v_first = y_up ? sy_r : sy_r - 1'b1;
    off_grid = ({1'b0, sx_r} >= grid_w) || ({1'b0, dx_r} >= grid_w) ||
               ({1'b0, sy_r} >= grid_h) || ({1'b0, dy_r} >= grid_h);
    same_pin = (sx_r == dx_r) && (sy_r == dy_r);
    tgt_bad  = (tgt_r >= total) || ({1'b0, tgt_r} >= TOP_W'(EDGE_SLOTS));
    // Highest edge touched: vertical edges sit above all horizontal ones
    if (y_move) begin
      top_w = {1'b0, hcount} + {1'b0, vtop_r} + TOP_W'(dx_r);
    end else begin
      top_w = {1'b0, hrow_r} + TOP_W'(xmax) - 1'b1;
    end
    top_bad = (top_w >= TOP_W'(EDGE_SLOTS));
    drop    = (kind_r == KIND_ROUTE) && top_bad;
  end

  // Share one row multiplier over the three sequencer steps
  always_comb begin
    unique case (state_r)
      F_MULH: begin
        mul_a = sy_r;
        mul_b = grid_w - 1'b1;
      end
      F_MULT: begin
        mul_a = y_move ? ymax - 1'b1 : '0;
        mul_b = grid_w;
      end
      F_MULV: begin
        mul_a = y_move ? v_first : '0;
        mul_b = grid_w;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = EDGE_W'(EDGE_W'(mul_a) * EDGE_W'(mul_b));
  end

  // Build the queued word
  always_comb begin
    if (kind_r == KIND_RELEASE) begin
      op = OP_RELEASE;
    end else if (kind_r == KIND_SETCAP) begin
      op = OP_SETCAP;
    end else begin
      op = OP_ROUTE;
    end
    cmd.op       = op;
    cmd.edge_idx = (kind_r == KIND_ROUTE) ? hrow_r + EDGE_W'(h_first) : tgt_r;
    cmd.h_steps  = h_steps;
    cmd.h_up     = x_up;
    cmd.v_start  = hcount + vrow_r + EDGE_W'(dx_r);
    cmd.v_steps  = v_steps;
    cmd.v_up     = y_up;
    cmd.cap      = capv_r;
  end

  assign push = (state_r == F_PUSH) && !drop && !fifo_full;
  assign idle = (state_r == F_IDLE);

  // Step the classifier
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_MULH;
        end
      end
      F_MULH: begin
        if (kind_r == KIND_ROUTE) begin
          state_nxt = (off_grid || same_pin) ? F_IDLE : F_MULT;
        end else if ((kind_r == KIND_RELEASE) || (kind_r == KIND_SETCAP)) begin
          state_nxt = F_MULT;
        end else begin
          state_nxt = F_IDLE;
        end
      end
      F_MULT: begin
        if (kind_r == KIND_ROUTE) begin
          state_nxt = F_MULV;
        end else begin
          state_nxt = tgt_bad ? F_IDLE : F_PUSH;
        end
      end
      F_MULV: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (drop || !fifo_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the item and the row products
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      sx_r   <= src_x;
      sy_r   <= src_y;
      dx_r   <= dst_x;
      dy_r   <= dst_y;
      tgt_r  <= target_edge;
      capv_r <= capacity_value;
    end
    if (state_r == F_MULH) begin
      hrow_r <= prod;
    end
    if (state_r == F_MULT) begin
      vtop_r <= prod;
    end
    if (state_r == F_MULV) begin
      vrow_r <= prod;
    end
  end

endmodule
`default_nettype wire

/* rtl/lrue_back.sv */
`default_nettype none
module lrue_back #(
  parameter int EDGE_SLOTS = lrue_pkg::EDGE_SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lrue_pkg::cmd_t               cmd,
  input  wire logic                         fifo_empty,
  output logic                              pop,
  input  wire logic [lrue_pkg::DIM_W-1:0]   grid_w,
  input  wire logic [lrue_pkg::UTIL_W-1:0]  default_capacity,
  output logic                              clearing,
  output logic                              out_valid,
  output logic [lrue_pkg::EDGE_W-1:0]       out_edge_index,
  output logic [lrue_pkg::UTIL_W-1:0]       out_utilization,
  output logic [lrue_pkg::UTIL_W-1:0]       out_overflow,
  output logic                              out_last
);
  import lrue_pkg::*;

  localparam int AW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;

  // Edge stores
  logic [UTIL_W-1:0] util_mem [EDGE_SLOTS];
  logic [UTIL_W-1:0] ovr_mem  [EDGE_SLOTS];
  logic              vld_mem  [EDGE_SLOTS];

  logic          clearing_r;
  logic [AW-1:0] clr_addr_r;

  // Walker
  logic               act_r, act_nxt;
  op_t                op_r, op_nxt;
  logic [EDGE_W-1:0]  edge_r, edge_nxt;
  logic [EDGE_W-1:0]  vstart_r, vstart_nxt;
  logic [COORD_W-1:0] h_left_r, h_left_nxt;
  logic [COORD_W-1:0] v_left_r, v_left_nxt;
  logic               h_up_r, h_up_nxt;
  logic               v_up_r, v_up_nxt;
  logic               in_v_r, in_v_nxt;
  logic [UTIL_W-1:0]  cap_r, cap_nxt;
  logic               step_last;

  // Update stage
  logic              wv_r;
  logic [EDGE_W-1:0] w_edge_r;
  op_t               w_op_r;
  logic              w_last_r;
  logic [UTIL_W-1:0] w_cap_r;
  logic [UTIL_W-1:0] util_q, ovr_q;
  logic              vld_q;
  logic [UTIL_W-1:0] cap_eff, util_new, ovf;

  // Output word
  logic              out_valid_r;
  logic [EDGE_W-1:0] out_edge_r;
  logic [UTIL_W-1:0] out_util_r, out_ovf_r;
  logic              out_last_r;

  logic              util_we, ovr_we, vld_we, vld_wd;
  logic [AW-1:0]     wr_addr;

  assign clearing = clearing_r;
  assign pop      = !clearing_r && !act_r && !wv_r && !fifo_empty;

  // Load a word, then walk its edges one per cycle
  always_comb begin
    act_nxt    = act_r;
    op_nxt     = op_r;
    edge_nxt   = edge_r;
    vstart_nxt = vstart_r;
    h_left_nxt = h_left_r;
    v_left_nxt = v_left_r;
    h_up_nxt   = h_up_r;
    v_up_nxt   = v_up_r;
    in_v_nxt   = in_v_r;
    cap_nxt    = cap_r;
    step_last  = in_v_r ? (v_left_r == COORD_W'(1)) :
                          ((h_left_r == COORD_W'(1)) && (v_left_r == '0));
    priority if (pop) begin
      act_nxt    = 1'b1;
      op_nxt     = cmd.op;
      cap_nxt    = cmd.cap;
      h_up_nxt   = cmd.h_up;
      v_up_nxt   = cmd.v_up;
      vstart_nxt = cmd.v_start;
      if (cmd.op == OP_ROUTE) begin
        h_left_nxt = cmd.h_steps;
        v_left_nxt = cmd.v_steps;
        in_v_nxt   = (cmd.h_steps == '0);
        edge_nxt   = (cmd.h_steps == '0) ? cmd.v_start : cmd.edge_idx;
      end else begin
        h_left_nxt = COORD_W'(1);
        v_left_nxt = '0;
        in_v_nxt   = 1'b0;
        edge_nxt   = cmd.edge_idx;
      end
    end else if (act_r) begin
      if (step_last) begin
        act_nxt = 1'b0;
      end
      if (in_v_r) begin
        v_left_nxt = v_left_r - 1'b1;
        edge_nxt   = v_up_r ? edge_r + EDGE_W'(grid_w) : edge_r - EDGE_W'(grid_w);
      end else begin
        h_left_nxt = h_left_r - 1'b1;
        if (h_left_r == COORD_W'(1)) begin
          in_v_nxt = 1'b1;
          edge_nxt = vstart_r;
        end else begin
          edge_nxt = h_up_r ? edge_r + 1'b1 : edge_r - 1'b1;
        end
      end
    end else begin
      act_nxt = act_r;
    end
  end

  // Work out the new utilisation and overflow of the edge in the update stage
  always_comb begin
    if (w_op_r == OP_SETCAP) begin
      cap_eff = w_cap_r;
    end else begin
      cap_eff = vld_q ? ovr_q : default_capacity;
    end
    unique case (w_op_r)
      OP_ROUTE:   util_new = (util_q == '1) ? util_q : util_q + 1'b1;
      OP_RELEASE: util_new = (util_q == '0) ? util_q : util_q - 1'b1;
      OP_SETCAP:  util_new = util_q;
      default:    util_new = util_q;
    endcase
    ovf = (util_new > cap_eff) ? util_new - cap_eff : '0;
  end

  // Steer the write ports: the clearing pass owns them after reset
  always_comb begin
    wr_addr = clearing_r ? clr_addr_r : w_edge_r[AW-1:0];
    util_we = clearing_r || (wv_r && (w_op_r != OP_SETCAP));
    ovr_we  = !clearing_r && wv_r && (w_op_r == OP_SETCAP);
    vld_we  = clearing_r || (wv_r && (w_op_r == OP_SETCAP));
    vld_wd  = !clearing_r;
  end

  always_ff @(posedge clk) begin
    if (util_we) begin
      util_mem[wr_addr] <= clearing_r ? '0 : util_new;
    end
    if (ovr_we) begin
      ovr_mem[wr_addr] <= w_cap_r;
    end
    if (vld_we) begin
      vld_mem[wr_addr] <= vld_wd;
    end
  end

  // Read the edge being walked
  always_ff @(posedge clk) begin
    if (act_r) begin
      util_q <= util_mem[edge_r[AW-1:0]];
      ovr_q  <= ovr_mem[edge_r[AW-1:0]];
      vld_q  <= vld_mem[edge_r[AW-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_addr_r  <= '0;
      act_r       <= 1'b0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(EDGE_SLOTS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      act_r       <= act_nxt;
      wv_r        <= act_r;
      out_valid_r <= wv_r;
    end
  end

  // Walker and pipeline payload
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    edge_r   <= edge_nxt;
    vstart_r <= vstart_nxt;
    h_left_r <= h_left_nxt;
    v_left_r <= v_left_nxt;
    h_up_r   <= h_up_nxt;
    v_up_r   <= v_up_nxt;
    in_v_r   <= in_v_nxt;
    cap_r    <= cap_nxt;
    if (act_r) begin
      w_edge_r <= edge_r;
      w_op_r   <= op_r;
      w_last_r <= step_last;
      w_cap_r  <= cap_r;
    end
    if (wv_r) begin
      out_edge_r <= w_edge_r;
      out_util_r <= util_new;
      out_ovf_r  <= ovf;
      out_last_r <= w_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_edge_index  = out_edge_r;
  assign out_utilization = out_util_r;
  assign out_overflow    = out_ovf_r;
  assign out_last        = out_last_r;

endmodule
`default_nettype wire

/* rtl/l_route_edge_utilization.sv */
`default_nettype none
`include "l_route_edge_utilization_defines.svh"
// L-shaped edge router. After reset the block sweeps the utilisation and override-valid
// stores, one entry a cycle, over EDGE_SLOTS entries (2048 by default) with busy high;
// configuration writes are taken at any time (cfg_ready is always high). An item is taken
// when start is high and busy is low. A four-step classifier (one shared row multiplier)
// checks each item and queues it. If the queue has room, busy drops again after the
// MULH, MULT, MULV and PUSH steps for a route, after MULH, MULT and PUSH for a release
// or capacity write, and sooner for an item that is rejected early, while the walker
// may still be working. The walker takes one queued word at a time and does one
// read-modify-write of an edge per cycle: a route of n unit steps gives n results on
// consecutive cycles through the walker, update and output registers; the walker is
// free once its last edge has left the update stage. A release or capacity write gives
// one result. Each result is shown for exactly one cycle with out_valid high and
// out_last marking the item's final word; the receiver cannot hold results off.
module l_route_edge_utilization #(
  parameter int MAX_GRID   = lrue_pkg::MAX_GRID_DEF,
  parameter int EDGE_SLOTS = lrue_pkg::EDGE_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [lrue_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [lrue_pkg::COORD_W-1:0]    in_src_x,
  input  wire logic [lrue_pkg::COORD_W-1:0]    in_src_y,
  input  wire logic [lrue_pkg::COORD_W-1:0]    in_dst_x,
  input  wire logic [lrue_pkg::COORD_W-1:0]    in_dst_y,
  input  wire logic [lrue_pkg::EDGE_W-1:0]     in_target_edge,
  input  wire logic [lrue_pkg::UTIL_W-1:0]     in_capacity_value,
  output logic                                 out_valid,
  output logic [lrue_pkg::EDGE_W-1:0]          out_edge_index,
  output logic [lrue_pkg::UTIL_W-1:0]          out_utilization,
  output logic [lrue_pkg::UTIL_W-1:0]          out_overflow,
  output logic                                 out_last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lrue_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lrue_pkg::UTIL_W-1:0]     cfg_data
);
  import lrue_pkg::*;

  logic [DIM_W-1:0]  grid_width_r, grid_height_r;
  logic [UTIL_W-1:0] def_cap_r;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [EDGE_W-1:0] hcount_r, vcount_r, total_r;

  logic  accept, front_idle, clearing;
  logic  push, pop, fifo_full, fifo_empty;
  cmd_t  front_cmd, head_cmd;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = clearing || !front_idle;

  // Take configuration words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
      def_cap_r     <= DEF_CAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data[DIM_W-1:0];
        CFG_DEF_CAP:     def_cap_r     <= cfg_data;
        default:         def_cap_r     <= def_cap_r;
      endcase
    end
  end

  // Clamp the grid to the supported size
  always_comb begin
    if (grid_width_r < DIM_W'(2)) begin
      w_eff = DIM_W'(2);
    end else if (grid_width_r > DIM_W'(MAX_GRID)) begin
      w_eff = DIM_W'(MAX_GRID);
    end else begin
      w_eff = grid_width_r;
    end
    if (grid_height_r < DIM_W'(2)) begin
      h_eff = DIM_W'(2);
    end else if (grid_height_r > DIM_W'(MAX_GRID)) begin
      h_eff = DIM_W'(MAX_GRID);
    end else begin
      h_eff = grid_height_r;
    end
  end

  // Track the edge counts of the grid in use
  always_ff @(posedge clk) begin
    hcount_r <= EDGE_W'(EDGE_W'(h_eff) * EDGE_W'(w_eff - 1'b1));
    vcount_r <= EDGE_W'(EDGE_W'(w_eff) * EDGE_W'(h_eff - 1'b1));
    total_r  <= hcount_r + vcount_r;
  end

  lrue_front #(
    .EDGE_SLOTS (EDGE_SLOTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .kind           (in_kind),
    .src_x          (in_src_x),
    .src_y          (in_src_y),
    .dst_x          (in_dst_x),
    .dst_y          (in_dst_y),
    .target_edge    (in_target_edge),
    .capacity_value (in_capacity_value),
    .grid_w         (w_eff),
    .grid_h         (h_eff),
    .hcount         (hcount_r),
    .total          (total_r),
    .fifo_full      (fifo_full),
    .push           (push),
    .cmd            (front_cmd),
    .idle           (front_idle)
  );

  lrue_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (front_cmd),
    .pop    (pop),
    .rd_cmd (head_cmd),
    .full   (fifo_full),
    .empty  (fifo_empty)
  );

  lrue_back #(
    .EDGE_SLOTS (EDGE_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (head_cmd),
    .fifo_empty       (fifo_empty),
    .pop              (pop),
    .grid_w           (w_eff),
    .default_capacity (def_cap_r),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_edge_index   (out_edge_index),
    .out_utilization  (out_utilization),
    .out_overflow     (out_overflow),
    .out_last         (out_last)
  );

  // No word may leave while the stores are still being cleared
  `LRUE_ASSERT_NOW(a_no_word_in_clear, clearing, !out_valid, "word during clearing pass")
  // Overflow is utilisation less a capacity and never exceeds it
  `LRUE_ASSERT_NOW(a_ovf_bound, out_valid, out_utilization >= out_overflow, "overflow too big")
  // The classifier holds off the next item right after an accept
  `LRUE_ASSERT_NEXT(a_busy_after_accept, accept, busy, "not busy after accept")

endmodule
`default_nettype wire
